// File: src/phase_voltage_modulator_core_assert.svh
// ----------------------------------------------------------------------------
// Phase voltage modulator assertion macros
// Shorthand for clocked checks that are disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PHASE_VOLTAGE_MODULATOR_CORE_ASSERT_SVH
`define PHASE_VOLTAGE_MODULATOR_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PVM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("phase voltage modulator check failed");

// Check cons in the cycle after ante.
`define PVM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("phase voltage modulator check failed");

`endif

// File: src/pvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase voltage modulator package
// Widths, codes, sine table and sector tables shared by the modulator.
// ----------------------------------------------------------------------------
package pvm_pkg;

    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int SINE_IDX_BITS      = $clog2(SINE_TABLE_ENTRIES);
    localparam int SIN_ONE            = 16384;
    localparam int SQRT3_HALF_Q14     = 14189;

    localparam int VOLT_W       = 16;
    localparam int ANGLE_W      = 16;
    localparam int SUPPLY_W     = 15;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 15;
    localparam int AB_W         = 18;
    localparam int PH_W         = 20;
    localparam int SAT_IN_W     = 24;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 88;
    localparam int PARK_LAT     = 5;
    localparam int PIPE_DEPTH   = 7;

    localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 15'd3072;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MODE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_CENTERED = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SUPPLY   = 2'd2;

    typedef enum logic [1:0] {
        MODE_SINE    = 2'd0,
        MODE_SVM     = 2'd1,
        MODE_TRAP120 = 2'd2,
        MODE_TRAP150 = 2'd3
    } mod_mode_t;

    typedef logic signed [VOLT_W-1:0] volt_t;
    typedef logic signed [AB_W-1:0]   ab_t;
    typedef logic signed [PH_W-1:0]   phase_t;
    typedef logic signed [1:0]        level_t;
    typedef level_t                   level_row_t [3];
    typedef volt_t                    sine_lut_t [SINE_TABLE_ENTRIES];

    localparam level_t LV_Z = 2'sb00;
    localparam level_t LV_P = 2'sb01;
    localparam level_t LV_N = 2'sb11;

    localparam level_row_t SECTOR120 [6] = '{
        '{LV_Z, LV_P, LV_N}, '{LV_N, LV_P, LV_Z}, '{LV_N, LV_Z, LV_P},
        '{LV_Z, LV_N, LV_P}, '{LV_P, LV_N, LV_Z}, '{LV_P, LV_Z, LV_N}
    };

    localparam level_row_t SECTOR150 [12] = '{
        '{LV_Z, LV_P, LV_N}, '{LV_N, LV_P, LV_N}, '{LV_N, LV_P, LV_Z},
        '{LV_N, LV_P, LV_P}, '{LV_N, LV_Z, LV_P}, '{LV_N, LV_N, LV_P},
        '{LV_Z, LV_N, LV_P}, '{LV_P, LV_N, LV_P}, '{LV_P, LV_N, LV_Z},
        '{LV_P, LV_N, LV_N}, '{LV_P, LV_Z, LV_N}, '{LV_P, LV_P, LV_N}
    };

    // Quarter-wave quintic, z in Q15, result in Q14
    function automatic longint quarter_sine(input longint z);
        longint z2;
        longint t;
        z2 = (z * z) >>> 15;
        t  = (longint'(2320) * z2) >>> 15;
        t  = longint'(21023) - t;
        t  = (t * z2) >>> 15;
        t  = longint'(51472) - t;
        t  = (((z * t) >>> 15) + longint'(1)) >>> 1;
        if (t > longint'(SIN_ONE)) begin
            t = longint'(SIN_ONE);
        end
        return t;
    endfunction

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t lut;
        longint    p;
        longint    r;
        longint    z;
        longint    s;
        longint    quad;
        for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
            p    = (longint'(k) * 65536 / SINE_TABLE_ENTRIES) % 65536;
            quad = p >>> 14;
            r    = p % 16384;
            z    = ((quad % 2) != 0) ? (longint'(16384) - r) * 2 : r * 2;
            s    = quarter_sine(z);
            if (quad >= 2) begin
                s = -s;
            end
            lut[k] = VOLT_W'(s);
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

    function automatic volt_t sat16(input logic signed [SAT_IN_W-1:0] v);
        if (v > SAT_IN_W'(32767)) begin
            return 16'sh7FFF;
        end
        if (v < -SAT_IN_W'(32768)) begin
            return 16'sh8000;
        end
        return v[VOLT_W-1:0];
    endfunction

endpackage

// File: src/phase_voltage_modulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase voltage modulator core
// Turns q/d voltage commands and an electrical angle into three phase levels.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per q/d voltage pair and angle.
// Result channel m_*: one item per input item, three saturated phase
// voltages, three phase enables and the alpha/beta pair (zero in trap modes).
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_addr
// (0 mode, 1 centered output, 2 supply voltage); write only while idle.
// Throughput: one item per cycle when not stalled; the seven stage pipeline (table lookup,
// products, alpha/beta sums, Clarke product, phases, min/max and sector,
// output) holds one item in each stage.
// Stall: while m_tvalid is high and m_tready is low the whole pipeline
// holds and s_tready is low; nothing is dropped or repeated.
// Reset: aresetn low clears all valid bits and loads the register defaults
// (sine mode, not centered, supply 12.0 V).
// ----------------------------------------------------------------------------
`include "phase_voltage_modulator_core_assert.svh"

module phase_voltage_modulator_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // q_volt[15:0], d_volt[31:16], angle[47:32]
    input  logic [pvm_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // phase_a_voltage[15:0], phase_b_voltage[31:16], phase_c_voltage[47:32],
    // phase_a_enable[48], phase_b_enable[49], phase_c_enable[50],
    // alpha_voltage[66:51], beta_voltage[82:67], zero[87:83]
    output logic [pvm_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [pvm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pvm_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import pvm_pkg::*;

    logic adv;
    logic [PIPE_DEPTH-1:0] valid_reg;

    mod_mode_t             mode_reg;
    logic                  centered_reg;
    logic [SUPPLY_W-1:0]   supply_reg;

    volt_t                 in_vq, in_vd;
    logic [ANGLE_W-1:0]    in_angle;

    ab_t                   alpha5, beta5;
    phase_t                ph5 [3];

    volt_t                 vq_dly_reg    [PARK_LAT];
    logic [ANGLE_W-1:0]    angle_dly_reg [PARK_LAT];

    volt_t                 vq5;
    logic [ANGLE_W-1:0]    angle5;
    logic [ANGLE_W+2:0]    sec120_sum;
    logic [ANGLE_W+3:0]    sec150_sum;
    logic [2:0]            sec120;
    logic [3:0]            sec150;
    logic [3:0]            sec150_inc;
    level_row_t            trap_row_next;
    phase_t                mn_next, mx_next;

    phase_t                ph6_reg [3];
    phase_t                mn6_reg, mx6_reg;
    ab_t                   alpha6_reg, beta6_reg;
    volt_t                 vq6_reg;
    level_row_t            trap_row6_reg;
    logic [2:0]            trap_en6;

    volt_t                 ph_next [3];
    logic [2:0]            en_next;
    volt_t                 alpha_next, beta_next;
    volt_t                 ph_out_reg [3];
    logic [2:0]            en_out_reg;
    volt_t                 alpha_out_reg, beta_out_reg;

    assign adv      = !valid_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[PIPE_DEPTH-1];

    assign in_vq    = s_tdata[15:0];
    assign in_vd    = s_tdata[31:16];
    assign in_angle = s_tdata[47:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_SINE;
            centered_reg <= 1'b0;
            supply_reg   <= SUPPLY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IDX_MODE:     mode_reg     <= mod_mode_t'(cfg_wr_data[1:0]);
                CFG_IDX_CENTERED: centered_reg <= cfg_wr_data[0];
                CFG_IDX_SUPPLY:   supply_reg   <= cfg_wr_data[SUPPLY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    pvm_inv_park_clarke u_park (
        .aclk    (aclk),
        .adv     (adv),
        .vq_i    (in_vq),
        .vd_i    (in_vd),
        .angle_i (in_angle),
        .alpha_o (alpha5),
        .beta_o  (beta5),
        .phase_o (ph5)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            vq_dly_reg[0]    <= in_vq;
            angle_dly_reg[0] <= in_angle;
            for (int i = 1; i < PARK_LAT; i++) begin
                vq_dly_reg[i]    <= vq_dly_reg[i-1];
                angle_dly_reg[i] <= angle_dly_reg[i-1];
            end
        end
    end

    assign vq5    = vq_dly_reg[PARK_LAT-1];
    assign angle5 = angle_dly_reg[PARK_LAT-1];

    // sector 120: round(6 * angle / turn) mod 6; sector 150: (12 * angle / turn + 1) mod 12
    assign sec120_sum = ((ANGLE_W+3)'(angle5) << 2) + ((ANGLE_W+3)'(angle5) << 1)
                        + (ANGLE_W+3)'(32768);
    assign sec150_sum = ((ANGLE_W+4)'(angle5) << 3) + ((ANGLE_W+4)'(angle5) << 2);
    assign sec120     = (sec120_sum[ANGLE_W+2:ANGLE_W] == 3'd6) ? 3'd0
                        : sec120_sum[ANGLE_W+2:ANGLE_W];
    assign sec150_inc = sec150_sum[ANGLE_W+3:ANGLE_W] + 4'd1;
    assign sec150     = (sec150_inc == 4'd12) ? 4'd0 : sec150_inc;

    always_comb begin
        if (mode_reg == MODE_TRAP120) begin
            trap_row_next = SECTOR120[sec120];
        end else begin
            trap_row_next = SECTOR150[sec150];
        end
        mn_next = ph5[0];
        mx_next = ph5[0];
        for (int i = 1; i < 3; i++) begin
            if (ph5[i] < mn_next) begin
                mn_next = ph5[i];
            end
            if (ph5[i] > mx_next) begin
                mx_next = ph5[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ph6_reg       <= ph5;
            mn6_reg       <= mn_next;
            mx6_reg       <= mx_next;
            alpha6_reg    <= alpha5;
            beta6_reg     <= beta5;
            vq6_reg       <= vq5;
            trap_row6_reg <= trap_row_next;
        end
    end

    assign trap_en6 = {trap_row6_reg[2] != LV_Z, trap_row6_reg[1] != LV_Z,
                       trap_row6_reg[0] != LV_Z};

    always_comb begin
        logic signed [SAT_IN_W-1:0] supply_s;
        logic signed [SAT_IN_W-1:0] center_s;
        logic signed [SAT_IN_W-1:0] center_t;
        logic signed [SAT_IN_W-1:0] lvl;
        logic signed [SAT_IN_W-1:0] v;
        logic                       is_trap;
        supply_s = SAT_IN_W'(signed'({1'b0, supply_reg}));
        center_s = supply_s;
        if (mode_reg == MODE_SVM) begin
            center_s = supply_s - SAT_IN_W'(mx6_reg) - SAT_IN_W'(mn6_reg);
        end
        center_t = centered_reg ? supply_s : (SAT_IN_W'(vq6_reg) <<< 1);
        is_trap  = (mode_reg == MODE_TRAP120) || (mode_reg == MODE_TRAP150);
        for (int i = 0; i < 3; i++) begin
            case (trap_row6_reg[i])
                LV_P:    lvl = SAT_IN_W'(vq6_reg);
                LV_N:    lvl = -SAT_IN_W'(vq6_reg);
                default: lvl = '0;
            endcase
            if (is_trap) begin
                v = ((lvl <<< 1) + center_t + SAT_IN_W'(1)) >>> 1;
            end else if (centered_reg) begin
                v = ((SAT_IN_W'(ph6_reg[i]) <<< 1) + center_s + SAT_IN_W'(1)) >>> 1;
            end else begin
                v = SAT_IN_W'(ph6_reg[i]) - SAT_IN_W'(mn6_reg);
            end
            ph_next[i] = sat16(v);
        end
        en_next    = is_trap ? trap_en6 : 3'b111;
        alpha_next = is_trap ? '0 : sat16(SAT_IN_W'(alpha6_reg));
        beta_next  = is_trap ? '0 : sat16(SAT_IN_W'(beta6_reg));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ph_out_reg    <= ph_next;
            en_out_reg    <= en_next;
            alpha_out_reg <= alpha_next;
            beta_out_reg  <= beta_next;
        end
    end

    assign m_tdata = {5'd0, beta_out_reg, alpha_out_reg, en_out_reg,
                      ph_out_reg[2], ph_out_reg[1], ph_out_reg[0]};

    `PVM_ASSERT_NEXT(a_stall_holds_pipe, !adv, $stable(valid_reg))
    `PVM_ASSERT_NEXT(a_accept_fills_first_stage, s_tvalid && s_tready, valid_reg[0])
    `PVM_ASSERT_SAME(a_output_from_minmax_stage, $rose(m_tvalid), $past(valid_reg[PIPE_DEPTH-2]))
    `PVM_ASSERT_SAME(a_sector_drives_two, valid_reg[PIPE_DEPTH-2], $countones(trap_en6) >= 2)

endmodule

// File: src/pvm_inv_park_clarke.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverse Park and Clarke pipeline
// Five stages: table lookup, products, alpha/beta, Clarke product, phases.
// ----------------------------------------------------------------------------
module pvm_inv_park_clarke (
    input  logic                          aclk,
    input  logic                          adv,
    input  pvm_pkg::volt_t                vq_i,
    input  pvm_pkg::volt_t                vd_i,
    input  logic [pvm_pkg::ANGLE_W-1:0]   angle_i,
    output pvm_pkg::ab_t                  alpha_o,
    output pvm_pkg::ab_t                  beta_o,
    output pvm_pkg::phase_t               phase_o [3]
);
    import pvm_pkg::*;

    localparam int PROD_W = 32;
    localparam int SUM_W  = 33;
    localparam int CL_W   = 34;
    localparam logic [SINE_IDX_BITS-1:0] QUARTER_IDX = SINE_IDX_BITS'(SINE_TABLE_ENTRIES / 4);

    logic [SINE_IDX_BITS-1:0] sin_idx;
    logic [SINE_IDX_BITS-1:0] cos_idx;

    volt_t sin_reg, cos_reg, vq1_reg, vd1_reg;
    logic signed [PROD_W-1:0] cd_reg, sq_reg, sd_reg, cq_reg;
    ab_t alpha3_reg, beta3_reg;
    logic signed [SUM_W-1:0] a_sum, b_sum;
    ab_t alpha4_reg, beta4_reg;
    logic signed [SUM_W-1:0] clarke_m_reg;
    logic signed [CL_W-1:0] cl_base, cl_b, cl_c;
    ab_t alpha5_reg, beta5_reg;
    phase_t ph_a_reg, ph_b_reg, ph_c_reg;

    assign sin_idx = angle_i[ANGLE_W-1 -: SINE_IDX_BITS];
    assign cos_idx = sin_idx + QUARTER_IDX;

    assign a_sum = SUM_W'(cd_reg) - SUM_W'(sq_reg) + SUM_W'(8192);
    assign b_sum = SUM_W'(sd_reg) + SUM_W'(cq_reg) + SUM_W'(8192);

    assign cl_base = -(CL_W'(alpha4_reg) <<< 13) + CL_W'(8192);
    assign cl_b    = cl_base + CL_W'(clarke_m_reg);
    assign cl_c    = cl_base - CL_W'(clarke_m_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sin_reg      <= SINE_LUT[sin_idx];
            cos_reg      <= SINE_LUT[cos_idx];
            vq1_reg      <= vq_i;
            vd1_reg      <= vd_i;

            cd_reg       <= cos_reg * vd1_reg;
            sq_reg       <= sin_reg * vq1_reg;
            sd_reg       <= sin_reg * vd1_reg;
            cq_reg       <= cos_reg * vq1_reg;

            alpha3_reg   <= a_sum[AB_W+13:14];
            beta3_reg    <= b_sum[AB_W+13:14];

            alpha4_reg   <= alpha3_reg;
            beta4_reg    <= beta3_reg;
            clarke_m_reg <= SUM_W'(beta3_reg) * SUM_W'(SQRT3_HALF_Q14);

            alpha5_reg   <= alpha4_reg;
            beta5_reg    <= beta4_reg;
            ph_a_reg     <= PH_W'(alpha4_reg);
            ph_b_reg     <= cl_b[PH_W+13:14];
            ph_c_reg     <= cl_c[PH_W+13:14];
        end
    end

    assign alpha_o    = alpha5_reg;
    assign beta_o     = beta5_reg;
    assign phase_o[0] = ph_a_reg;
    assign phase_o[1] = ph_b_reg;
    assign phase_o[2] = ph_c_reg;

endmodule
